[rtl/core/bf_pkg.sv]
// Shared types and constants for the FNV-1a Bloom filter.
`default_nettype none
package bf_pkg;

  // Eleven hash lanes, each with its own seed
  localparam int NUM_HASHES = 11;
  localparam int HASH_IDX_W = 4;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [31:0] SEEDS [NUM_HASHES] = '{
    32'd2166136261, 32'd1154, 32'd2181, 32'd4230, 32'd8331, 32'd16532,
    32'd32933, 32'd65734, 32'd131335, 32'd262536, 32'd523937
  };

  // Controls from the sequencer to the hash lanes
  typedef struct packed {
    logic step;   // fold in one key byte
    logic shift;  // rotate lanes so the next hash sits at the head
    logic seed;   // reload seeds for the next key
  } hash_ctl_t;

  // One FNV-1a step: xor the byte in, then multiply by the prime mod 2^32
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    fnv_step = x * FNV_PRIME;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bloom_filter_fnv1a.sv]
// Top level: FNV-1a Bloom filter sequencer over a word-wide bit store.
//
//   channel | signals                             | dir | notes
//   --------+-------------------------------------+-----+-------------------------
//   in      | in_valid in_stall operation         | in  | one key byte per beat
//           | key_byte last_byte                  |     |
//   out     | out_valid out_stall was_query       | out | one beat per finished key
//           | present                             |     |
//
// Sequence: a key byte that is not last is folded into every hash lane as it
// is accepted. A last byte starts eleven read-modify-write passes over the
// single store (registered read state, then update state), then a finish state.
// Reset: a clearing pass writes zero to all 2^(ADDR_BITS-6) store words,
// one per cycle, with in_stall held high.
// Stalls: bytes keep flowing while a result waits; a finished key waits
// for the output register before the hashes reseed.
`default_nettype none
module bloom_filter_fnv1a #(
  parameter int ADDR_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       operation,
  input  wire logic [7:0] key_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            was_query,
  output logic            present
);
  import bf_pkg::*;

  localparam int WA    = ADDR_BITS - 6;
  localparam int DEPTH = 1 << WA;
  localparam logic [HASH_IDX_W-1:0] LAST_IDX = HASH_IDX_W'(NUM_HASHES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]            state, state_next;
  logic [WA-1:0]         clr_addr;
  logic [HASH_IDX_W-1:0] cnt;
  logic                  op_query;
  logic                  all_set;
  logic [31:0]           head;
  hash_ctl_t             hctl;
  logic                  accept;
  logic                  out_free;
  logic                  ram_we;
  logic [WA-1:0]         ram_waddr;
  logic [63:0]           ram_wdata;
  logic [63:0]           ram_rdata;
  logic                  hit_bit;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign hit_bit  = ram_rdata[head[5:0]];

  // Hash lane control
  always_comb begin
    hctl.step  = accept;
    hctl.shift = (state == S_UPDATE);
    hctl.seed  = (state == S_DONE) && out_free;
  end

  bf_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hctl),
    .key_byte (key_byte),
    .head     (head)
  );

  // Store write port: zero sweep after reset, bit set on add
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head[ADDR_BITS-1:6];
    ram_wdata = ram_rdata | (64'd1 << head[5:0]);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_UPDATE && !op_query) begin
      ram_we = 1'b1;
    end
  end

  bf_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (head[ADDR_BITS-1:6]),
    .rd_data (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE:   if (accept && last_byte) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = (cnt == LAST_IDX) ? S_DONE : S_READ;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_UPDATE) begin
        cnt <= (cnt == LAST_IDX) ? '0 : cnt + 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Key context and result payload
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      op_query <= operation;
      all_set  <= 1'b1;
    end else if (state == S_UPDATE) begin
      all_set <= all_set & hit_bit;
    end
    if (state == S_DONE && out_free) begin
      was_query <= op_query;
      present   <= op_query & all_set;
    end
  end

  // Checks
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside finish step");

  a_present_query: assert property (@(posedge clk) disable iff (rst)
    (out_valid && present) |-> was_query)
    else $error("present flagged on an add");

  a_read_then_update: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_UPDATE)
    else $error("store read not followed by update");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_IDX)
    else $error("hash counter out of range");

endmodule
`default_nettype wire

[rtl/core/bf_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/core/bf_hash.sv]
// Eleven running FNV-1a hash lanes with a rotating head for store lookups.
`default_nettype none
module bf_hash (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bf_pkg::hash_ctl_t ctl,
  input  wire logic [7:0]        key_byte,
  output logic      [31:0]       head
);
  import bf_pkg::*;

  logic [31:0] lane [NUM_HASHES];

  // Lane update: seed, rotate toward the head, or hash one byte
  always_ff @(posedge clk) begin
    if (rst || ctl.seed) begin
      for (int i = 0; i < NUM_HASHES; i++) begin
        lane[i] <= SEEDS[i];
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < NUM_HASHES - 1; i++) begin
        lane[i] <= lane[i+1];
      end
      lane[NUM_HASHES-1] <= lane[0];
    end else if (ctl.step) begin
      for (int i = 0; i < NUM_HASHES; i++) begin
        lane[i] <= fnv_step(lane[i], key_byte);
      end
    end
  end

  assign head = lane[0];

endmodule
`default_nettype wire
